FILE: hw/rtl/fss_pkg.sv
// Shared types, constants and helpers for the fuzzy subsequence scorer.
// No dependencies; imported by every module of the block.
package fss_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned PosW       = 4;
  localparam int unsigned SelW       = 3;
  localparam int unsigned ScoreW     = 9;
  localparam int unsigned ResW       = 10;
  localparam int unsigned CfgAddrW   = 1;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [ScoreW-1:0] MatchBase     = 9'd10;
  localparam logic [ScoreW-1:0] BoundaryBonus = 9'd8;
  localparam logic [ResW-1:0]   ResNoMatch    = '1;
  localparam logic [ResW-1:0]   ResMax        = 10'd284;

  localparam logic [CfgAddrW-1:0] RegPatternChars  = 1'b0;
  localparam logic [CfgAddrW-1:0] RegPatternLength = 1'b1;

  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChDash       = 8'h2D;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChDot        = 8'h2E;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] ChUpperZ     = 8'h5A;
  localparam logic [7:0] CaseOffset   = 8'h20;

  typedef struct packed {
    logic [MaxPattern-1:0][7:0] chars;
    logic [PosW-1:0]            len;
  } pattern_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= ChUpperA && b <= ChUpperZ) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    return (b == ChUnderscore) || (b == ChDash) || (b == ChSpace) ||
           (b == ChTab) || (b == ChDot);
  endfunction

endpackage

FILE: hw/rtl/fss_cfg.sv
// Pattern registers: folded pattern bytes and clamped pattern length.
// Depends on fss_pkg.
module fss_cfg import fss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output pattern_t            pattern_o
);

  logic [MaxPattern-1:0][7:0] chars_q, chars_d;
  logic [PosW-1:0]            len_q, len_d;

  always_comb begin
    chars_d = chars_q;
    len_d   = len_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegPatternChars: begin
          for (int i = 0; i < MaxPattern; i++) begin
            chars_d[i] = fold_case(cfg_data_i[8*i +: 8]);
          end
        end
        RegPatternLength: len_d = cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
      len_q   <= '0;
    end else begin
      chars_q <= chars_d;
      len_q   <= len_d;
    end
  end

  assign pattern_o.chars = chars_q;
  assign pattern_o.len   = (len_q > PosW'(MaxPattern)) ? PosW'(MaxPattern) : len_q;

endmodule

FILE: hw/rtl/fss_score.sv
// Per-name match state and the one-byte score update.
// Depends on fss_pkg.
module fss_score import fss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  input  pattern_t        pattern_i,
  output logic            res_valid_o,
  output logic [ResW-1:0] res_score_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   run_q, run_d;
  logic [ScoreW-1:0] score_q, score_d;
  logic [7:0]        prev_q, prev_d;
  logic              start_q, start_d;

  logic              active;
  logic              hit;
  logic [7:0]        pat_char;
  logic [ScoreW-1:0] add;
  logic [PosW-1:0]   pos_upd;
  logic [PosW-1:0]   run_upd;
  logic [ScoreW-1:0] score_upd;

  assign active   = pos_q < pattern_i.len;
  assign pat_char = pattern_i.chars[pos_q[SelW-1:0]];
  assign hit      = active && (fold_case(char_i) == pat_char);
  assign add      = MatchBase + ScoreW'({run_q, 2'b00}) + ScoreW'(run_q) +
                    ((start_q || is_separator(prev_q)) ? BoundaryBonus : '0);

  always_comb begin
    pos_upd   = pos_q;
    run_upd   = run_q;
    score_upd = score_q;
    if (hit) begin
      pos_upd   = pos_q + 1'b1;
      run_upd   = run_q + 1'b1;
      score_upd = score_q + add;
    end else if (active) begin
      run_upd = '0;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    run_d   = run_q;
    score_d = score_q;
    prev_d  = prev_q;
    start_d = start_q;
    if (step_i) begin
      if (last_i) begin
        pos_d   = '0;
        run_d   = '0;
        score_d = '0;
        prev_d  = '0;
        start_d = 1'b1;
      end else begin
        pos_d   = pos_upd;
        run_d   = run_upd;
        score_d = score_upd;
        prev_d  = char_i;
        start_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      run_q   <= '0;
      score_q <= '0;
      prev_q  <= '0;
      start_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      run_q   <= run_d;
      score_q <= score_d;
      prev_q  <= prev_d;
      start_q <= start_d;
    end
  end

  assign res_valid_o = step_i && last_i;

  always_comb begin
    priority if (pattern_i.len == '0) begin
      res_score_o = '0;
    end else if (pos_upd >= pattern_i.len) begin
      res_score_o = {1'b0, score_upd};
    end else begin
      res_score_o = ResNoMatch;
    end
  end

endmodule

FILE: hw/rtl/fuzzy_subsequence_scorer.sv
// Top level of the fuzzy subsequence scorer: input register, scoring, result register.
// Depends on fss_pkg, fss_cfg and fss_score.
//
// Streams a name one byte per item and scores it against the configured pattern
// (up to eight bytes, case-insensitive, greedy subsequence match). One result item
// leaves for each item marked tlast: the score, or -1 when the pattern was not fully
// matched, 0 for an empty pattern. Throughput is one byte per cycle except while a last
// byte waits. A last byte passes through the input register, and its score is loaded into
// the result register when it leaves that register. A last byte waits in the input
// register only while the previous result is still held by the output; other bytes
// never wait. Write the pattern registers only while no name is in flight.
module fuzzy_subsequence_scorer import fss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] text_char
  input  logic                s_axis_tlast,   // last_char
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [9:0] match_score, [15:10] zero
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_char_q;
  logic            in_last_q;
  logic            out_valid_q, out_valid_d;
  logic [ResW-1:0] out_score_q;
  logic            step;
  logic            s_fire;
  logic            res_valid;
  logic [ResW-1:0] res_score;
  pattern_t        pattern;

  assign cfg_ready_o = 1'b1;

  fss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .pattern_o  (pattern)
  );

  assign step          = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  fss_score u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .char_i     (in_char_q),
    .last_i     (in_last_q),
    .pattern_i  (pattern),
    .res_valid_o(res_valid),
    .res_score_o(res_score)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (res_valid) begin
      out_score_q <= res_score;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_score_q};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !res_valid)
    else $error("result register overwritten while stalled");

  a_result_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !in_last_q) |-> !res_valid)
    else $error("result produced for a byte not marked last");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_score == ResNoMatch || res_score <= ResMax))
    else $error("score out of range");

  a_step_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> in_valid_q)
    else $error("step without a held item");

endmodule

FILE: tb/fuzzy_subsequence_scorer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for fuzzy_subsequence_scorer: streams names and checks each score.
// Depends on fss_pkg and the fuzzy_subsequence_scorer RTL; needs nothing else.
module fuzzy_subsequence_scorer_tb import fss_pkg::*; ();

  localparam int unsigned CycleLimit = 150000;
  localparam int unsigned ItemGoal   = 1300;

  class name_scoreboard;
    logic [CfgDataW-1:0] pat_chars;
    logic [PosW-1:0]     pat_len;
    logic [PosW-1:0]     matched;
    logic [PosW-1:0]     run;
    logic [ScoreW-1:0]   score;
    logic [7:0]          prev;
    logic                fresh;
    logic [ResW-1:0]     pending_scores[$];
    int                  errors;

    function new();
      pat_chars = '0;
      pat_len   = '0;
      errors    = 0;
      start_name();
    endfunction

    function void start_name();
      matched = '0;
      run     = '0;
      score   = '0;
      prev    = '0;
      fresh   = 1'b1;
    endfunction

    function void note_score(logic [ResW-1:0] s);
      pending_scores.insert(pending_scores.size(), s);
    endfunction

    function logic [7:0] fold_letter(logic [7:0] b);
      return (b >= ChUpperA && b <= ChUpperZ) ? (b | 8'h20) : b;
    endfunction

    function bit is_boundary(logic [7:0] b);
      return b == ChUnderscore || b == ChDash || b == ChSpace || b == ChTab || b == ChDot;
    endfunction

    function int unsigned active_len();
      return (pat_len > MaxPattern) ? MaxPattern : pat_len;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      if (addr == RegPatternChars) begin
        pat_chars = data;
      end else begin
        pat_len = data[PosW-1:0];
      end
    endfunction

    function void add_byte(logic [7:0] ch, logic last);
      int unsigned lim;
      int unsigned bonus;
      logic [7:0]  want;
      lim = active_len();
      if (matched < lim) begin
        want = fold_letter(pat_chars[8*matched +: 8]);
        if (fold_letter(ch) == want) begin
          bonus   = (fresh || is_boundary(prev)) ? 8 : 0;
          score   = ScoreW'(score + 10 + 5 * run + bonus);
          run     = run + 1'b1;
          matched = matched + 1'b1;
        end else begin
          run = '0;
        end
      end
      prev  = ch;
      fresh = 1'b0;
      if (last) begin
        if (lim == 0) begin
          note_score('0);
        end else if (matched >= lim) begin
          note_score({1'b0, score});
        end else begin
          note_score(ResNoMatch);
        end
        start_name();
      end
    endfunction

    function void check_score(logic [15:0] beat);
      logic [ResW-1:0] want;
      if (pending_scores.size() == 0) begin
        $error("match_score: expected none, actual %0d", $signed(beat[ResW-1:0]));
        errors++;
        return;
      end
      want = pending_scores.pop_front();
      if (beat[ResW-1:0] !== want) begin
        $error("match_score: expected %0d, actual %0d", $signed(want),
               $signed(beat[ResW-1:0]));
        errors++;
      end
      if (beat[15:ResW] !== '0) begin
        $error("tdata pad: expected 0, actual %0h", beat[15:ResW]);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [7:0]          s_data = '0;
  logic                s_last = 1'b0;
  logic                m_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [15:0]         m_axis_tdata;
  logic                cfg_ready_o;

  name_scoreboard sb = new();
  bit             steady = 1'b0;
  int unsigned    sent = 0;
  int unsigned    cycles = 0;
  logic [7:0]     name_q[$];

  fuzzy_subsequence_scorer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [CfgDataW-1:0] pack_pattern(string s);
    logic [CfgDataW-1:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < MaxPattern; i++) begin
      r[8*i +: 8] = s[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 5) begin
      case ($urandom_range(0, 4))
        0: return ChUnderscore;
        1: return ChDash;
        2: return ChSpace;
        3: return ChTab;
        default: return ChDot;
      endcase
    end else if (r < 13) begin
      return 8'($urandom_range(8'h61, 8'h7A)) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    end
    return 8'($urandom);
  endfunction

  function automatic void queue_byte(logic [7:0] c);
    name_q.insert(name_q.size(), c);
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic last);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.add_byte(ch, last);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_name(input string s, input bit ff_tail = 1'b0);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], !ff_tail && i == s.len() - 1);
    end
    if (ff_tail) begin
      send_byte(8'hFF, 1'b1);
    end
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    while (sb.pending_scores.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_pattern(input logic [CfgDataW-1:0] chars, input logic [PosW-1:0] len);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= (i == 0) ? RegPatternChars : RegPatternLength;
      cfg_data  <= (i == 0) ? chars : CfgDataW'(len);
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg((i == 0) ? RegPatternChars : RegPatternLength,
                   (i == 0) ? chars : CfgDataW'(len));
      @(negedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pattern(input int phase);
    logic [CfgDataW-1:0] chars;
    logic [PosW-1:0]     len;
    case ($urandom_range(0, 9))
      0, 1: chars = {$urandom, $urandom};
      2:    chars = '1;
      default: begin
        for (int i = 0; i < MaxPattern; i++) chars[8*i +: 8] = pick_byte();
      end
    endcase
    if (phase == 4) chars = '1;
    case (phase)
      0: len = PosW'(MaxPattern);
      1: len = '1;
      2: len = '0;
      default: begin
        case ($urandom_range(0, 5))
          0: len = '0;
          1: len = PosW'($urandom_range(MaxPattern + 1, 15));
          default: len = PosW'($urandom_range(1, MaxPattern));
        endcase
      end
    endcase
    set_pattern(chars, len);
  endtask

  task automatic make_name();
    int unsigned kind;
    int unsigned lim;
    int unsigned drop;
    logic [7:0]  c;
    name_q.delete();
    kind = $urandom_range(0, 9);
    lim  = sb.active_len();
    drop = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
    if (kind < 2) begin
      repeat ($urandom_range(1, 12)) queue_byte(pick_byte());
    end else begin
      for (int i = 0; i < lim; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 2)) queue_byte(pick_byte());
        end
        if (kind == 2 && i == drop) continue;
        c = sb.pat_chars[8*i +: 8];
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1)) begin
          c = c ^ 8'h20;
        end
        queue_byte(c);
      end
      repeat ($urandom_range(0, 2)) queue_byte(pick_byte());
      if (name_q.size() == 0) queue_byte(pick_byte());
    end
    foreach (name_q[i]) send_byte(name_q[i], i == name_q.size() - 1);
  endtask

  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        m_ready <= 1'b0;
        @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_score(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  initial begin
    int          phase;
    int unsigned phase_end;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_pattern('0, '0);
    send_byte(8'h00, 1'b1);
    wait_idle();
    set_pattern(pack_pattern("Ab"), 4'd2);
    send_name("aB");
    send_name("x_a-B");
    send_name("a");
    wait_idle();
    set_pattern(pack_pattern("abcdefgh"), 4'd15);
    send_name("abCDefgh", 1'b1);
    wait_idle();
    set_pattern(pack_pattern("xyz"), 4'd3);
    send_name("\tx.y z");
    wait_idle();

    phase = 0;
    while (sent < ItemGoal) begin
      steady = (phase % 4 == 3);
      random_pattern(phase);
      phase_end = sent + 100;
      while (sent < phase_end) make_name();
      wait_idle();
      phase++;
    end

    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
